/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros included by sign_magnitude_q32_32_alu
// Clocked implication checks, disabled while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define SMQ_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define SMQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/smq_pkg.sv */
// ---------------------------------------------------------------------------
// smq_pkg
// Widths, opcodes and sequencer states of the sign-magnitude Q32.32 ALU.
// ---------------------------------------------------------------------------
`default_nettype none

package smq_pkg;

    localparam int FRAC_W    = 32;
    localparam int MAG_W     = 2 * FRAC_W;
    localparam int MUL_STEPS = MAG_W;
    localparam int DIV_STEPS = MAG_W + FRAC_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_MUL = 2'd1;
    localparam logic [1:0] OP_DIV = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_ADD_SWAP,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } smq_state_t;

endpackage

`default_nettype wire

/* rtl/smq_addsub.sv */
// ---------------------------------------------------------------------------
// smq_addsub
// Shared 66-bit adder/subtractor; bit 65 of a difference is the borrow.
// ---------------------------------------------------------------------------
`default_nettype none

module smq_addsub (
    input  logic [smq_pkg::MAG_W:0]   x,
    input  logic [smq_pkg::MAG_W-1:0] y,
    input  logic                      sub,
    output logic [smq_pkg::MAG_W+1:0] s
);
    import smq_pkg::*;

    logic [MAG_W+1:0] x_ext;
    logic [MAG_W+1:0] y_ext;

    assign x_ext = {1'b0, x};
    assign y_ext = sub ? ~{2'b00, y} : {2'b00, y};
    assign s     = x_ext + y_ext + {{(MAG_W + 1){1'b0}}, sub};

endmodule

`default_nettype wire

/* rtl/sign_magnitude_q32_32_alu.sv */
// Add makes one adder pass, plus a swapped pass when b is larger in magnitude with
// unlike signs; a zero divisor or dividend or an unused opcode goes straight to done.
// Multiply runs one shift-add step per cycle and divide one restoring step
// per cycle (96 steps over the widened dividend), both on one 66-bit adder.
// A new item is taken only after the previous result has moved to the output
// register. Reset (rst_n low, asynchronous) returns to idle with no output.
// ---------------------------------------------------------------------------
// sign_magnitude_q32_32_alu
// Sign-magnitude Q32.32 add, multiply and divide on a shared adder.
// ---------------------------------------------------------------------------
`default_nettype none

module sign_magnitude_q32_32_alu (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 req_type,
    input  logic                       a_negative,
    input  logic [smq_pkg::FRAC_W-1:0] a_whole,
    input  logic [smq_pkg::FRAC_W-1:0] a_fraction,
    input  logic                       b_negative,
    input  logic [smq_pkg::FRAC_W-1:0] b_whole,
    input  logic [smq_pkg::FRAC_W-1:0] b_fraction,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       r_negative,
    output logic [smq_pkg::FRAC_W-1:0] r_whole,
    output logic [smq_pkg::FRAC_W-1:0] r_fraction,
    output logic                       divide_by_zero
);
    import smq_pkg::*;

    smq_state_t       state_reg, state_next;
    logic [MAG_W-1:0] a_reg, a_next;
    logic [MAG_W-1:0] b_reg, b_next;
    logic [MAG_W-1:0] x_reg, x_next;
    logic [MAG_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             a_neg_reg, a_neg_next;
    logic             b_neg_reg, b_neg_next;
    logic             rneg_reg, rneg_next;
    logic [MAG_W-1:0] rmag_reg, rmag_next;
    logic             dz_reg, dz_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_neg_reg, out_neg_next;
    logic [MAG_W-1:0] out_mag_reg, out_mag_next;
    logic             out_dz_reg, out_dz_next;

    logic [MAG_W-1:0] am;
    logic [MAG_W-1:0] bm;
    logic             a_zero;
    logic             b_zero;
    logic             in_take;
    logic             out_free;
    logic             step_last;
    logic             div_ge;
    logic [MAG_W:0]   ux;
    logic [MAG_W-1:0] uy;
    logic             usub;
    logic [MAG_W+1:0] us;

    assign am        = {a_whole, a_fraction};
    assign bm        = {b_whole, b_fraction};
    assign a_zero    = (am == '0);
    assign b_zero    = (bm == '0);
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !(out_valid_reg && out_stall);
    assign step_last = (cnt_reg == '0);
    assign div_ge    = !us[MAG_W+1];

    smq_addsub u_addsub (
        .x   (ux),
        .y   (uy),
        .sub (usub),
        .s   (us)
    );

    // Route operands into the shared adder for the current step.
    always_comb
    begin
        ux   = '0;
        uy   = '0;
        usub = 1'b0;
        unique case (state_reg)
            ST_ADD:
            begin
                ux   = {1'b0, a_reg};
                uy   = b_reg;
                usub = a_neg_reg ^ b_neg_reg;
            end
            ST_ADD_SWAP:
            begin
                ux   = {1'b0, b_reg};
                uy   = a_reg;
                usub = 1'b1;
            end
            ST_MUL:
            begin
                ux   = {1'b0, x_reg};
                uy   = b_reg[0] ? a_reg : '0;
                usub = 1'b0;
            end
            ST_DIV:
            begin
                ux   = {x_reg, a_reg[MAG_W-1]};
                uy   = b_reg;
                usub = 1'b1;
            end
            default:
            begin
                ux   = '0;
                uy   = '0;
                usub = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (req_type)
                        OP_ADD:  state_next = ST_ADD;
                        OP_MUL:  state_next = ST_MUL;
                        OP_DIV:  state_next = (a_zero || b_zero) ? ST_DONE : ST_DIV;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_ADD:
            begin
                if (usub && us[MAG_W+1])
                    state_next = ST_ADD_SWAP;
                else
                    state_next = ST_DONE;
            end
            ST_ADD_SWAP: state_next = ST_DONE;
            ST_MUL:      state_next = step_last ? ST_DONE : ST_MUL;
            ST_DIV:      state_next = step_last ? ST_DONE : ST_DIV;
            ST_DONE:     state_next = out_free ? ST_IDLE : ST_DONE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and output register updates.
    always_comb
    begin
        a_next         = a_reg;
        b_next         = b_reg;
        x_next         = x_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        a_neg_next     = a_neg_reg;
        b_neg_next     = b_neg_reg;
        rneg_next      = rneg_reg;
        rmag_next      = rmag_reg;
        dz_next        = dz_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_neg_next   = out_neg_reg;
        out_mag_next   = out_mag_reg;
        out_dz_next    = out_dz_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    a_next     = am;
                    b_next     = bm;
                    a_neg_next = a_negative;
                    b_neg_next = b_negative;
                    x_next     = '0;
                    q_next     = '0;
                    rneg_next  = 1'b0;
                    rmag_next  = '0;
                    dz_next    = 1'b0;
                    unique case (req_type)
                        OP_ADD:
                        begin
                            cnt_next = '0;
                        end
                        OP_MUL:
                        begin
                            cnt_next  = CNT_W'(MUL_STEPS - 1);
                            rneg_next = a_negative ^ b_negative;
                        end
                        OP_DIV:
                        begin
                            cnt_next  = CNT_W'(DIV_STEPS - 1);
                            dz_next   = b_zero;
                            rneg_next = !a_zero && !b_zero && (a_negative ^ b_negative);
                        end
                        default:
                        begin
                            cnt_next = '0;
                        end
                    endcase
                end
            end
            ST_ADD:
            begin
                if (!usub)
                begin
                    rmag_next = us[MAG_W-1:0];
                    rneg_next = a_neg_reg;
                end
                else if (us[MAG_W+1])
                begin
                    rneg_next = b_neg_reg;
                end
                else if (us[MAG_W-1:0] == '0)
                begin
                    rmag_next = '0;
                    rneg_next = 1'b0;
                end
                else
                begin
                    rmag_next = us[MAG_W-1:0];
                    rneg_next = a_neg_reg;
                end
            end
            ST_ADD_SWAP:
            begin
                rmag_next = us[MAG_W-1:0];
            end
            ST_MUL:
            begin
                // Shift the partial sum right; low product bits collect in q.
                x_next   = us[MAG_W:1];
                q_next   = {us[0], q_reg[MAG_W-1:1]};
                b_next   = b_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (step_last)
                    rmag_next = {us[FRAC_W:0], q_reg[MAG_W-1:FRAC_W+1]};
            end
            ST_DIV:
            begin
                // Keep the difference when the shifted remainder covers the divisor.
                x_next   = div_ge ? us[MAG_W-1:0] : ux[MAG_W-1:0];
                a_next   = a_reg << 1;
                q_next   = {q_reg[MAG_W-2:0], div_ge};
                cnt_next = cnt_reg - 1'b1;
                if (step_last)
                    rmag_next = {q_reg[MAG_W-2:0], div_ge};
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_neg_next   = rneg_reg;
                    out_mag_next   = rmag_reg;
                    out_dz_next    = dz_reg;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        x_reg       <= x_next;
        q_reg       <= q_next;
        a_neg_reg   <= a_neg_next;
        b_neg_reg   <= b_neg_next;
        rneg_reg    <= rneg_next;
        rmag_reg    <= rmag_next;
        dz_reg      <= dz_next;
        out_neg_reg <= out_neg_next;
        out_mag_reg <= out_mag_next;
        out_dz_reg  <= out_dz_next;
    end

    assign out_valid      = out_valid_reg;
    assign r_negative     = out_neg_reg;
    assign r_whole        = out_mag_reg[MAG_W-1:FRAC_W];
    assign r_fraction     = out_mag_reg[FRAC_W-1:0];
    assign divide_by_zero = out_dz_reg;

`include "assert_macros.svh"

    `SMQ_ASSERT_IMPLY(a_dz_zero_result, out_valid && divide_by_zero,
        !r_negative && r_whole == '0 && r_fraction == '0,
        "divide-by-zero result is not positive zero")
    `SMQ_ASSERT_IMPLY(a_mul_cnt_range, state_reg == ST_MUL,
        cnt_reg < CNT_W'(MUL_STEPS), "multiply step count out of range")
    `SMQ_ASSERT_NEXT(a_done_loads_out, state_reg == ST_DONE && out_free,
        out_valid && state_reg == ST_IDLE, "finished item not moved to output")
    `SMQ_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall,
        state_reg != ST_IDLE, "accepted item left sequencer idle")

endmodule

`default_nettype wire
